### design/msha_pkg.sv
package msha_pkg;

   localparam int MAX_LEAVES = 1024;
   localparam int NODE_W     = 11;
   localparam int NODES      = 2048;
   localparam int SPAN_W     = 12;
   localparam int HEIGHT_W   = 4;
   localparam int WORD_W     = 32;
   localparam int HASH_W     = 160;
   localparam int WIDX_W     = 3;
   localparam int LC_W       = 11;
   localparam int RND_W      = 7;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_BUILD = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [WIDX_W-1:0] LAST_WORD = 3'd4;
   localparam logic [RND_W-1:0]  LAST_RND  = 7'd79;

   localparam logic [WORD_W-1:0] IV0 = 32'h67452301;
   localparam logic [WORD_W-1:0] IV1 = 32'hEFCDAB89;
   localparam logic [WORD_W-1:0] IV2 = 32'h98BADCFE;
   localparam logic [WORD_W-1:0] IV3 = 32'h10325476;
   localparam logic [WORD_W-1:0] IV4 = 32'hC3D2E1F0;

   // padding word after the 40-byte message and its bit length
   localparam logic [WORD_W-1:0] PAD_WORD = 32'h80000000;
   localparam logic [WORD_W-1:0] LEN_WORD = 32'd320;

   // smallest h with 2^h >= leaf count, count clamped to 1 .. MAX_LEAVES
   function automatic logic [HEIGHT_W-1:0] tree_height(input logic [LC_W-1:0] lc);
      logic [LC_W-1:0]     n;
      logic [HEIGHT_W-1:0] h;
      n = lc;
      if (n == '0) n = LC_W'(1);
      if (n > LC_W'(MAX_LEAVES)) n = LC_W'(MAX_LEAVES);
      h = '0;
      for (int i = 0; i < LC_W; i++) begin
         if ((SPAN_W'(1) << i) < SPAN_W'(n)) h = HEIGHT_W'(i + 1);
      end
      return h;
   endfunction

endpackage

### design/merkle_sha1_tree_builder.sv
// Binary hash tree store with an iterative SHA-1 engine.
// req channel: tuser carries the opcode (write word, build, read node); tdata
// carries node, word index and word value. rsp channel returns five words per
// hash, tlast on the fifth, tuser = {status, computed}.
// csr_wr_en/csr_wr_data set the leaf count; write it only while idle.
// Reset: the hash and flag memories are swept to zero, one entry per cycle,
// over all 2048 entries, with req_tready low.
// Write word: one transaction per cycle, no response.
// Read node: a registered memory read (S_RISS, S_RLOAD), then five response
// words, one per cycle while rsp_tready is high; a stall holds the current word.
// Build: a sweep over all 2048 entries clears the computed flags, then each
// node pair is read (S_RDL, S_RDR) and checked; if both children are zero the
// parent is written as zero, else 80 SHA-1 rounds run on a single round unit
// and the hash is written back; then the root is read and returned as for a read.
// The round unit sets the build time. req_tready is high only between transactions.
module merkle_sha1_tree_builder
   import msha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // node_index, word_index, word_value, zero pad
   input  logic [1:0]  req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // result_node, result_word_index, hash_word, zero pad
   output logic [1:0]  rsp_tuser,   // status, computed
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [10:0] csr_wr_data
);

   localparam logic [3:0] S_CLR   = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_RDL   = 4'd2;
   localparam logic [3:0] S_RDR   = 4'd3;
   localparam logic [3:0] S_CHK   = 4'd4;
   localparam logic [3:0] S_RND   = 4'd5;
   localparam logic [3:0] S_FIN   = 4'd6;
   localparam logic [3:0] S_RISS  = 4'd7;
   localparam logic [3:0] S_RLOAD = 4'd8;
   localparam logic [3:0] S_EMIT  = 4'd9;

   logic [3:0]          state_ff, state_in;
   logic [LC_W-1:0]     leaf_count_ff;
   logic [NODE_W-1:0]   clr_cnt_ff, clr_cnt_in;
   logic                clr_all_ff, clr_all_in;
   logic [HEIGHT_W-1:0] level_ff, level_in;
   logic [SPAN_W-1:0]   left_ff, left_in;
   logic [NODE_W-1:0]   node_ff, node_in;
   logic                in_tree_ff, in_tree_in;
   logic [WIDX_W-1:0]   word_ff, word_in;
   logic [HASH_W-1:0]   out_hash_ff, out_hash_in;
   logic                comp_ff, comp_in;
   logic [HASH_W-1:0]   left_hash_ff, left_hash_in;
   logic [RND_W-1:0]    rnd_ff, rnd_in;
   logic [WORD_W-1:0]   a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [WORD_W-1:0]   a_in, b_in, c_in, d_in, e_in;
   logic [WORD_W-1:0]   w_ff [16];
   logic [WORD_W-1:0]   w_in [16];

   logic [HASH_W-1:0]   hash_mem [NODES];
   logic                flag_mem [NODES];
   logic [HASH_W-1:0]   hash_rd_ff;
   logic                flag_rd_ff;
   logic [NODE_W-1:0]   rd_addr;
   logic                hash_full_we, hash_word_we, flag_we, flag_wdata;
   logic [NODE_W-1:0]   waddr;
   logic [HASH_W-1:0]   hash_wdata;

   logic [HEIGHT_W-1:0] height;
   logic [SPAN_W-1:0]   span;
   logic [SPAN_W-1:0]   root;
   logic [NODE_W-1:0]   req_node;
   logic [WIDX_W-1:0]   req_widx;
   logic [WORD_W-1:0]   req_value;
   logic                req_in_tree;
   logic                req_fire;
   logic [SPAN_W-1:0]   right, parent, left_step;
   logic [WORD_W-1:0]   f_val, k_val, t_val, w_new;

   assign height    = tree_height(leaf_count_ff);
   assign span      = SPAN_W'(2) << height;
   assign root      = (SPAN_W'(1) << height) - SPAN_W'(1);
   assign req_node  = req_tdata[10:0];
   assign req_widx  = req_tdata[13:11];
   assign req_value = req_tdata[45:14];
   assign req_in_tree = {1'b0, req_node} < (span - SPAN_W'(1));
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   assign right     = left_ff + (SPAN_W'(1) << level_ff);
   assign parent    = left_ff + (SPAN_W'(1) << (level_ff - HEIGHT_W'(1)));
   assign left_step = left_ff + (SPAN_W'(2) << level_ff);

   // one SHA-1 round
   always_comb begin
      if (rnd_ff < 7'd20) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = 32'h5A827999;
      end else if (rnd_ff < 7'd40) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = 32'h6ED9EBA1;
      end else if (rnd_ff < 7'd60) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = 32'h8F1BBCDC;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = 32'hCA62C1D6;
      end
      t_val = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + k_val + w_ff[0];
      w_new = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];
      w_new = {w_new[30:0], w_new[31]};
   end

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      clr_all_in   = clr_all_ff;
      level_in     = level_ff;
      left_in      = left_ff;
      node_in      = node_ff;
      in_tree_in   = in_tree_ff;
      word_in      = word_ff;
      out_hash_in  = out_hash_ff;
      comp_in      = comp_ff;
      left_hash_in = left_hash_ff;
      rnd_in       = rnd_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff; e_in = e_ff;
      w_in = w_ff;
      rd_addr      = node_ff;
      hash_full_we = 1'b0;
      hash_word_we = 1'b0;
      flag_we      = 1'b0;
      flag_wdata   = 1'b0;
      waddr        = parent[NODE_W-1:0];
      hash_wdata   = '0;

      case (state_ff)
         S_CLR: begin
            waddr   = clr_cnt_ff;
            flag_we = 1'b1;
            hash_full_we = clr_all_ff;
            clr_cnt_in = clr_cnt_ff + NODE_W'(1);
            if (clr_cnt_ff == NODE_W'(NODES - 1)) begin
               if (clr_all_ff) begin
                  state_in = S_IDLE;
               end else if (height == '0) begin
                  node_in    = '0;
                  in_tree_in = 1'b1;
                  state_in   = S_RISS;
               end else begin
                  level_in = HEIGHT_W'(1);
                  left_in  = '0;
                  state_in = S_RDL;
               end
            end
         end
         S_IDLE: begin
            rd_addr = req_node;
            if (req_fire) begin
               case (req_tuser)
                  OP_WRITE: begin
                     if (req_in_tree && req_widx <= LAST_WORD) begin
                        waddr        = req_node;
                        hash_word_we = 1'b1;
                        flag_we      = 1'b1;
                     end
                  end
                  OP_BUILD: begin
                     clr_all_in = 1'b0;
                     clr_cnt_in = '0;
                     state_in   = S_CLR;
                  end
                  OP_READ: begin
                     node_in    = req_node;
                     in_tree_in = req_in_tree;
                     state_in   = S_RISS;
                  end
                  default: ;
               endcase
            end
         end
         S_RDL: begin
            rd_addr  = left_ff[NODE_W-1:0];
            state_in = S_RDR;
         end
         S_RDR: begin
            rd_addr      = right[NODE_W-1:0];
            left_hash_in = hash_rd_ff;
            state_in     = S_CHK;
         end
         S_CHK: begin
            if (left_hash_ff == '0 && hash_rd_ff == '0) begin
               hash_full_we = 1'b1;
               flag_we      = 1'b1;
               flag_wdata   = 1'b1;
            end else begin
               for (int i = 0; i < 5; i++) begin
                  w_in[i]     = left_hash_ff[WORD_W*i +: WORD_W];
                  w_in[i + 5] = hash_rd_ff[WORD_W*i +: WORD_W];
               end
               w_in[10] = PAD_WORD;
               for (int i = 11; i < 15; i++) w_in[i] = '0;
               w_in[15] = LEN_WORD;
               a_in = IV0; b_in = IV1; c_in = IV2; d_in = IV3; e_in = IV4;
               rnd_in   = '0;
               state_in = S_RND;
            end
         end
         S_RND: begin
            a_in = t_val;
            b_in = a_ff;
            c_in = {b_ff[1:0], b_ff[31:2]};
            d_in = c_ff;
            e_in = d_ff;
            for (int i = 0; i < 15; i++) w_in[i] = w_ff[i + 1];
            w_in[15] = w_new;
            rnd_in = rnd_ff + RND_W'(1);
            if (rnd_ff == LAST_RND) state_in = S_FIN;
         end
         S_FIN: begin
            hash_full_we = 1'b1;
            flag_we      = 1'b1;
            flag_wdata   = 1'b1;
            hash_wdata   = {e_ff + IV4, d_ff + IV3, c_ff + IV2, b_ff + IV1, a_ff + IV0};
         end
         S_RISS: begin
            state_in = S_RLOAD;
         end
         S_RLOAD: begin
            out_hash_in = in_tree_ff ? hash_rd_ff : '0;
            comp_in     = in_tree_ff & flag_rd_ff;
            word_in     = '0;
            state_in    = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_tready) begin
               word_in = word_ff + WIDX_W'(1);
               if (word_ff == LAST_WORD) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // advance to the next pair once a parent is written
      if ((state_ff == S_CHK && state_in == S_CHK) || state_ff == S_FIN) begin
         if (left_step < span) begin
            left_in  = left_step;
            state_in = S_RDL;
         end else if (level_ff == height) begin
            node_in    = root[NODE_W-1:0];
            in_tree_in = 1'b1;
            state_in   = S_RISS;
         end else begin
            level_in = level_ff + HEIGHT_W'(1);
            left_in  = (SPAN_W'(1) << level_ff) - SPAN_W'(1);
            state_in = S_RDL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (hash_full_we) begin
         hash_mem[waddr] <= hash_wdata;
      end else if (hash_word_we) begin
         hash_mem[waddr][WORD_W*req_widx +: WORD_W] <= req_value;
      end
      hash_rd_ff <= hash_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (flag_we) flag_mem[waddr] <= flag_wdata;
      flag_rd_ff <= flag_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLR;
         clr_cnt_ff    <= '0;
         clr_all_ff    <= 1'b1;
         leaf_count_ff <= LC_W'(1);
         word_ff       <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         clr_all_ff <= clr_all_in;
         word_ff    <= word_in;
         if (csr_wr_en) leaf_count_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      level_ff     <= level_in;
      left_ff      <= left_in;
      node_ff      <= node_in;
      in_tree_ff   <= in_tree_in;
      out_hash_ff  <= out_hash_in;
      comp_ff      <= comp_in;
      left_hash_ff <= left_hash_in;
      rnd_ff       <= rnd_in;
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in; e_ff <= e_in;
      w_ff <= w_in;
   end

   assign rsp_tvalid = (state_ff == S_EMIT);
   assign rsp_tdata  = {2'b00, out_hash_ff[WORD_W*word_ff +: WORD_W], word_ff, node_ff};
   assign rsp_tuser  = {~in_tree_ff, comp_ff};
   assign rsp_tlast  = (word_ff == LAST_WORD);

   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(rsp_tvalid && req_tready))
      else $error("request and response open at once");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> (rsp_tdata[45:14] == '0 && !rsp_tuser[0]))
      else $error("out-of-tree node returned data");

   a_last_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> !rsp_tvalid)
      else $error("response continued after last word");

endmodule
